### rtl/core/r2y_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r2y_pkg
// Shared types and constants for the rgb to yuyv 4:2:2 converter.
// ----------------------------------------------------------------------------
package r2y_pkg;

    localparam int unsigned COMP_W = 8;
    localparam int unsigned SUM_W  = 17;
    localparam int unsigned FILT_W = 10;

    // bt.601 limited range coefficients, negative terms are subtracted
    localparam logic [SUM_W-1:0] K_Y_R = SUM_W'(66);
    localparam logic [SUM_W-1:0] K_Y_G = SUM_W'(129);
    localparam logic [SUM_W-1:0] K_Y_B = SUM_W'(25);
    localparam logic [SUM_W-1:0] K_U_R = SUM_W'(38);
    localparam logic [SUM_W-1:0] K_U_G = SUM_W'(74);
    localparam logic [SUM_W-1:0] K_U_B = SUM_W'(112);
    localparam logic [SUM_W-1:0] K_V_R = SUM_W'(112);
    localparam logic [SUM_W-1:0] K_V_G = SUM_W'(94);
    localparam logic [SUM_W-1:0] K_V_B = SUM_W'(18);
    localparam logic [SUM_W-1:0] K_RND = SUM_W'(128);
    // chroma offset of 128 folded in before the shift
    localparam logic [SUM_W-1:0] K_BIAS = SUM_W'(32768);

    localparam logic [COMP_W-1:0] Y_OFS     = COMP_W'(16);
    localparam logic [COMP_W-1:0] C_NEUTRAL = COMP_W'(128);
    localparam logic [COMP_W-1:0] Y_MIN     = COMP_W'(16);
    localparam logic [COMP_W-1:0] Y_MAX     = COMP_W'(235);
    localparam logic [COMP_W-1:0] C_MIN     = COMP_W'(16);
    localparam logic [COMP_W-1:0] C_MAX     = COMP_W'(240);

    typedef struct packed {
        logic              valid;
        logic              line_start;
        logic [COMP_W-1:0] y;
        logic [COMP_W-1:0] u;
        logic [COMP_W-1:0] v;
    } t_pix;

endpackage
`default_nettype wire

### rtl/core/r2y_csc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r2y_csc
// Input register and rgb to yuv color space conversion.
// ----------------------------------------------------------------------------
module r2y_csc (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [r2y_pkg::COMP_W-1:0] i_red,
    input  wire logic [r2y_pkg::COMP_W-1:0] i_green,
    input  wire logic [r2y_pkg::COMP_W-1:0] i_blue,
    input  wire logic                      i_line_start,
    input  wire logic                      i_take,
    output r2y_pkg::t_pix                  o_pix
);
    import r2y_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [COMP_W-1:0] r_red;
    logic [COMP_W-1:0] r_green;
    logic [COMP_W-1:0] r_blue;
    logic              r_line_start;
    logic              accept;
    logic [SUM_W-1:0]  sum_y;
    logic [SUM_W-1:0]  sum_u;
    logic [SUM_W-1:0]  sum_v;
    logic [SUM_W-1:0]  ext_r;
    logic [SUM_W-1:0]  ext_g;
    logic [SUM_W-1:0]  ext_b;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_red        <= i_red;
            r_green      <= i_green;
            r_blue       <= i_blue;
            r_line_start <= i_line_start;
        end
    end

    assign ext_r = SUM_W'(r_red);
    assign ext_g = SUM_W'(r_green);
    assign ext_b = SUM_W'(r_blue);

    // all sums stay in 0..65535, so bits 15:8 are the floored result
    assign sum_y = K_Y_R * ext_r + K_Y_G * ext_g + K_Y_B * ext_b + K_RND;
    assign sum_u = K_U_B * ext_b + K_RND + K_BIAS - K_U_R * ext_r - K_U_G * ext_g;
    assign sum_v = K_V_R * ext_r + K_RND + K_BIAS - K_V_G * ext_g - K_V_B * ext_b;

    always_comb begin
        o_pix.valid      = r_valid;
        o_pix.line_start = r_line_start;
        o_pix.y          = sum_y[15:8] + Y_OFS;
        o_pix.u          = sum_u[15:8];
        o_pix.v          = sum_v[15:8];
    end

endmodule
`default_nettype wire

### rtl/core/r2y_pack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r2y_pack
// Pairs pixels, filters chroma 1-2-1 at even columns and holds the output beat.
// ----------------------------------------------------------------------------
module r2y_pack (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire r2y_pkg::t_pix              i_pix,
    output logic                            o_take,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [r2y_pkg::COMP_W-1:0]      o_luma_first,
    output logic [r2y_pkg::COMP_W-1:0]      o_chroma_blue,
    output logic [r2y_pkg::COMP_W-1:0]      o_luma_second,
    output logic [r2y_pkg::COMP_W-1:0]      o_chroma_red
);
    import r2y_pkg::*;

    logic              r_phase;
    logic [COMP_W-1:0] r_held_y;
    logic [COMP_W-1:0] r_held_u;
    logic [COMP_W-1:0] r_held_v;
    logic [COMP_W-1:0] r_left_u;
    logic [COMP_W-1:0] r_left_v;
    logic              r_out_valid;
    logic [COMP_W-1:0] r_out_y0;
    logic [COMP_W-1:0] r_out_u;
    logic [COMP_W-1:0] r_out_y1;
    logic [COMP_W-1:0] r_out_v;

    logic              out_busy;
    logic              phase;
    logic              emit;
    logic              fire;
    logic [COMP_W-1:0] left_u;
    logic [COMP_W-1:0] left_v;
    logic [FILT_W-1:0] filt_u;
    logic [FILT_W-1:0] filt_v;

    // a line start always restarts at column 0 with a neutral left neighbor
    assign phase  = i_pix.line_start ? 1'b0 : r_phase;
    assign left_u = i_pix.line_start ? C_NEUTRAL : r_left_u;
    assign left_v = i_pix.line_start ? C_NEUTRAL : r_left_v;

    assign out_busy = r_out_valid && i_stall;
    assign emit     = phase;
    // even pixels need no output slot
    assign o_take   = i_pix.valid && (!emit || !out_busy);
    assign fire     = o_take && emit;

    assign filt_u = FILT_W'(left_u) + {1'b0, r_held_u, 1'b0} + FILT_W'(i_pix.u)
                  + FILT_W'(2);
    assign filt_v = FILT_W'(left_v) + {1'b0, r_held_v, 1'b0} + FILT_W'(i_pix.v)
                  + FILT_W'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_held_y    <= '0;
            r_held_u    <= C_NEUTRAL;
            r_held_v    <= C_NEUTRAL;
            r_left_u    <= C_NEUTRAL;
            r_left_v    <= C_NEUTRAL;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                if (!emit) begin
                    r_held_y <= i_pix.y;
                    r_held_u <= i_pix.u;
                    r_held_v <= i_pix.v;
                    r_left_u <= left_u;
                    r_left_v <= left_v;
                    r_phase  <= 1'b1;
                end else begin
                    r_left_u <= i_pix.u;
                    r_left_v <= i_pix.v;
                    r_phase  <= 1'b0;
                end
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_y0 <= r_held_y;
            r_out_u  <= filt_u[FILT_W-1:2];
            r_out_y1 <= i_pix.y;
            r_out_v  <= filt_v[FILT_W-1:2];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_luma_first  = r_out_y0;
    assign o_chroma_blue = r_out_u;
    assign o_luma_second = r_out_y1;
    assign o_chroma_red  = r_out_v;

    a_fire_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("completed pair did not reach the output register");

    a_start_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_pix.line_start) |=> r_phase)
        else $error("line start pixel not held as even pixel");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !fire)
        else $error("stalled output beat overwritten");

    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_y0 >= Y_MIN && r_out_y0 <= Y_MAX
                         && r_out_y1 >= Y_MIN && r_out_y1 <= Y_MAX
                         && r_out_u >= C_MIN && r_out_u <= C_MAX
                         && r_out_v >= C_MIN && r_out_v <= C_MAX))
        else $error("output component out of limited range");

endmodule
`default_nettype wire

### rtl/core/rgb_to_yuyv422_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_yuyv422_converter
// Streaming rgb to packed yuyv 4:2:2 conversion, bt.601 limited range.
// ----------------------------------------------------------------------------
// Input channel: one rgb pixel per beat on i_valid / o_stall, with
// i_line_start marking column 0 of a line. Output channel: one yuyv beat
// (y0, u, y1, v) on o_valid / i_stall for every even/odd pixel pair.
// Chroma is filtered 1-2-1 across columns at the even pixel, with 128 used
// left of column 0; the right tap is the odd pixel of the pair.
// Throughput: one pixel per clock while the output is not stalled; the limit
// is the single input register feeding the output register, each item passes
// each once. An output beat becomes valid after the odd pixel of its pair
// has passed the input register, then the output register.
// Even pixels never wait for the output register, so the input keeps flowing
// while a finished beat is stalled; an odd pixel waits in the input register
// until the beat ahead is taken, and o_stall rises behind it.
// A line start in mid pair drops the unpaired even pixel.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// pairing to an even pixel with neutral chroma history.
// ----------------------------------------------------------------------------
module rgb_to_yuyv422_converter (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [r2y_pkg::COMP_W-1:0] i_red,
    input  wire logic [r2y_pkg::COMP_W-1:0] i_green,
    input  wire logic [r2y_pkg::COMP_W-1:0] i_blue,
    input  wire logic                       i_line_start,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [r2y_pkg::COMP_W-1:0]      o_luma_first,
    output logic [r2y_pkg::COMP_W-1:0]      o_chroma_blue,
    output logic [r2y_pkg::COMP_W-1:0]      o_luma_second,
    output logic [r2y_pkg::COMP_W-1:0]      o_chroma_red
);
    import r2y_pkg::*;

    t_pix pix;
    logic take;

    r2y_csc u_csc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_line_start (i_line_start),
        .i_take       (take),
        .o_pix        (pix)
    );

    r2y_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix         (pix),
        .o_take        (take),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_luma_first  (o_luma_first),
        .o_chroma_blue (o_chroma_blue),
        .o_luma_second (o_luma_second),
        .o_chroma_red  (o_chroma_red)
    );

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the rgb to yuyv 4:2:2 converter. A queue of pixel beats
// (directed corner cases, then random lines of mixed shape) feeds a driver.
// A monitor predicts each yuyv beat when its pixel is taken and checks the
// output beats in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned CW = r2y_pkg::COMP_W;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
        logic          line_start;
        t_idle_mode    mode;
        logic          drain_first;
    } t_rgb_beat;

    typedef struct {
        logic [CW-1:0] y;
        logic [CW-1:0] u;
        logic [CW-1:0] v;
    } t_yuv;

    typedef struct {
        logic [CW-1:0] luma_first;
        logic [CW-1:0] chroma_blue;
        logic [CW-1:0] luma_second;
        logic [CW-1:0] chroma_red;
    } t_yuyv;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    logic [CW-1:0] i_red;
    logic [CW-1:0] i_green;
    logic [CW-1:0] i_blue;
    logic          i_line_start;
    logic          o_valid;
    logic          i_stall;
    logic [CW-1:0] o_luma_first;
    logic [CW-1:0] o_chroma_blue;
    logic [CW-1:0] o_luma_second;
    logic [CW-1:0] o_chroma_red;

    t_rgb_beat  pixel_queue[$];
    t_yuyv      yuyv_pending[$];
    int         error_count;
    logic       pix_taken;
    t_idle_mode cur_mode;

    // predictor state
    logic          odd_next;
    logic [CW-1:0] held_y;
    logic [CW-1:0] held_u;
    logic [CW-1:0] held_v;
    logic [CW-1:0] left_u;
    logic [CW-1:0] left_v;

    rgb_to_yuyv422_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_line_start  (i_line_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_luma_first  (o_luma_first),
        .o_chroma_blue (o_chroma_blue),
        .o_luma_second (o_luma_second),
        .o_chroma_red  (o_chroma_red)
    );

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_red        = '0;
        i_green      = '0;
        i_blue       = '0;
        i_line_start = 1'b0;
        pix_taken    = 1'b0;
        cur_mode     = IDLE_NONE;
        error_count  = 0;
        odd_next     = 1'b0;
        held_y       = '0;
        held_u       = r2y_pkg::C_NEUTRAL;
        held_v       = r2y_pkg::C_NEUTRAL;
        left_u       = r2y_pkg::C_NEUTRAL;
        left_v       = r2y_pkg::C_NEUTRAL;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic chance(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // mostly random bytes, with the rails hit often
    function automatic logic [CW-1:0] rand_comp();
        int unsigned pick;
        pick = $urandom_range(7);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return CW'($urandom_range(255));
    endfunction

    function automatic t_yuv rgb_to_yuv(input logic [CW-1:0] r, g, b);
        int   ri, gi, bi, ys, us, vs;
        t_yuv o;
        ri = int'(r);
        gi = int'(g);
        bi = int'(b);
        ys = 66 * ri + 129 * gi + 25 * bi + 128;
        // 32768 bias keeps the chroma sums positive and adds the 128 offset
        us = 112 * bi - 38 * ri - 74 * gi + 128 + 32768;
        vs = 112 * ri - 94 * gi - 18 * bi + 128 + 32768;
        o.y = CW'((ys >>> 8) + 16);
        o.u = CW'(us >>> 8);
        o.v = CW'(vs >>> 8);
        return o;
    endfunction

    function automatic logic [CW-1:0] chroma_121(input logic [CW-1:0] l, m, r);
        logic [CW+1:0] s;
        s = {2'b00, l} + {1'b0, m, 1'b0} + {2'b00, r} + (CW+2)'(2);
        return s[CW+1:2];
    endfunction

    task automatic predict_pixel(input logic [CW-1:0] r, g, b, input logic ls);
        t_yuv  c;
        t_yuyv w;
        c = rgb_to_yuv(r, g, b);
        if (ls) begin
            odd_next = 1'b0;
            left_u   = r2y_pkg::C_NEUTRAL;
            left_v   = r2y_pkg::C_NEUTRAL;
        end
        if (!odd_next) begin
            held_y   = c.y;
            held_u   = c.u;
            held_v   = c.v;
            odd_next = 1'b1;
        end else begin
            w.luma_first  = held_y;
            w.chroma_blue = chroma_121(left_u, held_u, c.u);
            w.luma_second = c.y;
            w.chroma_red  = chroma_121(left_v, held_v, c.v);
            yuyv_pending  = {yuyv_pending, w};
            left_u   = c.u;
            left_v   = c.v;
            odd_next = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic add_pixel(input logic [CW-1:0] r, g, b, input logic ls,
                             input t_idle_mode mode, input logic drain);
        t_rgb_beat p;
        p.red         = r;
        p.green       = g;
        p.blue        = b;
        p.line_start  = ls;
        p.mode        = mode;
        p.drain_first = drain;
        pixel_queue   = {pixel_queue, p};
    endtask

    task automatic add_line(input int unsigned width, input logic with_start,
                            input t_idle_mode mode, input logic drain);
        for (int unsigned k = 0; k < width; k++) begin
            add_pixel(rand_comp(), rand_comp(), rand_comp(), with_start && (k == 0),
                      mode, drain && (k == 0));
        end
    endtask

    // driver: a held beat stays put until taken, new beats go out at the falling edge
    always @(negedge i_clk) begin : driver
        t_rgb_beat nxt;
        logic      gap;
        if (i_rst_n) begin
            if (!i_valid || pix_taken) begin
                if (pixel_queue.size() > 0) begin
                    nxt = pixel_queue[0];
                    case (nxt.mode)
                        IDLE_SENDER: gap = chance(57);
                        IDLE_BOTH:   gap = chance(8);
                        default:     gap = 1'b0;
                    endcase
                    if (nxt.drain_first && yuyv_pending.size() != 0) gap = 1'b1;
                    if (!gap) begin
                        void'(pixel_queue.pop_front());
                        i_red        <= nxt.red;
                        i_green      <= nxt.green;
                        i_blue       <= nxt.blue;
                        i_line_start <= nxt.line_start;
                        i_valid      <= 1'b1;
                        cur_mode      = nxt.mode;
                    end else begin
                        i_valid <= 1'b0;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
            case (cur_mode)
                IDLE_RECEIVER: i_stall <= chance(57);
                IDLE_BOTH:     i_stall <= chance(8);
                default:       i_stall <= 1'b0;
            endcase
        end
    end

    // monitor: check output beats first, then predict from the pixel taken
    always @(posedge i_clk) begin : monitor
        t_yuyv want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (yuyv_pending.size() == 0) begin
                    report_mismatch($sformatf("output beat %h %h %h %h with nothing pending",
                                              o_luma_first, o_chroma_blue,
                                              o_luma_second, o_chroma_red));
                end else begin
                    want = yuyv_pending.pop_front();
                    if (o_luma_first !== want.luma_first)
                        report_mismatch($sformatf("luma_first %h, want %h",
                                                  o_luma_first, want.luma_first));
                    if (o_chroma_blue !== want.chroma_blue)
                        report_mismatch($sformatf("chroma_blue %h, want %h",
                                                  o_chroma_blue, want.chroma_blue));
                    if (o_luma_second !== want.luma_second)
                        report_mismatch($sformatf("luma_second %h, want %h",
                                                  o_luma_second, want.luma_second));
                    if (o_chroma_red !== want.chroma_red)
                        report_mismatch($sformatf("chroma_red %h, want %h",
                                                  o_chroma_red, want.chroma_red));
                end
            end
            if (i_valid && !o_stall) predict_pixel(i_red, i_green, i_blue, i_line_start);
            pix_taken <= i_valid && !o_stall;
        end else begin
            pix_taken <= 1'b0;
        end
    end

    initial begin : stimulus
        int unsigned total;
        int unsigned kind;
        t_idle_mode  mode;
        t_idle_mode  last_mode;

        // pairs straight after reset, no line start yet
        add_pixel(8'd0, 8'd0, 8'd0, 1'b0, IDLE_NONE, 1'b0);
        add_pixel(8'd255, 8'd255, 8'd255, 1'b0, IDLE_NONE, 1'b0);
        // primaries and rails on one even line
        add_pixel(8'd255, 8'd0, 8'd0, 1'b1, IDLE_NONE, 1'b0);
        add_pixel(8'd0, 8'd255, 8'd0, 1'b0, IDLE_NONE, 1'b0);
        add_pixel(8'd0, 8'd0, 8'd255, 1'b0, IDLE_NONE, 1'b0);
        add_pixel(8'd255, 8'd255, 8'd255, 1'b0, IDLE_NONE, 1'b0);
        add_pixel(8'd0, 8'd0, 8'd0, 1'b0, IDLE_NONE, 1'b0);
        add_pixel(8'd255, 8'd0, 8'd255, 1'b0, IDLE_NONE, 1'b0);
        // odd-width line, its tail even pixel is dropped by the next start
        add_pixel(8'd0, 8'd255, 8'd255, 1'b1, IDLE_NONE, 1'b0);
        add_pixel(8'd128, 8'd128, 8'd128, 1'b0, IDLE_NONE, 1'b0);
        add_pixel(8'd255, 8'd255, 8'd0, 1'b0, IDLE_NONE, 1'b0);
        add_pixel(8'd10, 8'd200, 8'd30, 1'b1, IDLE_NONE, 1'b0);
        add_pixel(8'd255, 8'd0, 8'd0, 1'b0, IDLE_NONE, 1'b0);
        // back to back line starts
        add_pixel(8'd255, 8'd255, 8'd255, 1'b1, IDLE_NONE, 1'b0);
        add_pixel(8'd0, 8'd0, 8'd0, 1'b1, IDLE_NONE, 1'b0);
        add_pixel(8'd0, 8'd0, 8'd0, 1'b0, IDLE_NONE, 1'b0);
        // stream carries on with no line start, left tap from the last odd pixel
        add_pixel(8'd0, 8'd0, 8'd255, 1'b0, IDLE_NONE, 1'b0);
        add_pixel(8'd255, 8'd0, 8'd0, 1'b0, IDLE_NONE, 1'b0);
        add_pixel(8'd0, 8'd255, 8'd0, 1'b0, IDLE_NONE, 1'b0);
        add_pixel(8'd0, 8'd0, 8'd0, 1'b0, IDLE_NONE, 1'b0);
        // lone even pixel, then a fresh line
        add_pixel(8'd200, 8'd100, 8'd50, 1'b1, IDLE_NONE, 1'b0);
        add_pixel(8'd1, 8'd2, 8'd3, 1'b1, IDLE_NONE, 1'b0);
        add_pixel(8'd254, 8'd253, 8'd252, 1'b0, IDLE_NONE, 1'b0);

        // random lines, idle mode changes every 225 beats
        total     = 0;
        last_mode = IDLE_BOTH;
        while (total < 1800) begin
            mode = t_idle_mode'((total / 225) % 4);
            kind = $urandom_range(99);
            if (kind < 80) begin
                add_line(2 * $urandom_range(1, 20), 1'b1, mode, mode != last_mode);
            end else if (kind < 88) begin
                add_line(2 * $urandom_range(0, 10) + 1, 1'b1, mode, mode != last_mode);
            end else if (kind < 94) begin
                add_line($urandom_range(1, 9), 1'b0, mode, mode != last_mode);
            end else begin
                for (int unsigned k = 0; k < 12; k++)
                    add_pixel(rand_comp(), rand_comp(), rand_comp(), chance(30), mode,
                              (mode != last_mode) && (k == 0));
            end
            last_mode = mode;
            total     = pixel_queue.size();
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pixel_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (yuyv_pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d beats still expected", yuyv_pending.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
